@@ rtl/core/vmu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_pkg
// Shared types and constants of the vessel maturity update pipeline.
// ----------------------------------------------------------------------------
package vmu_pkg;

	// maturity format, unsigned Q1.16
	localparam int          MFB     = 16;
	localparam int          MAT_W   = MFB + 1;
	localparam logic [16:0] MAT_ONE = 17'h10000;

	// log2(e) in Q1.30 and ln(2) in Q0.32
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;

	// 2^21 * 1e9: dt*s at or above this saturates the exponent
	localparam logic [51:0] XDEN = 52'd2097152000000000;

	// dt*s / 1e9 = ((dt*s) >> 9) / 5^9, by reciprocal floor(2^42 / 5^9)
	localparam logic [20:0] X_DIV   = 21'd1953125;
	localparam logic [21:0] X_RECIP = 22'd2251799;

	// exp series terms and reciprocal scale for the per-term divide
	localparam int SERIES_TERMS = 12;
	localparam int RECIP_SHIFT  = 35;

	// register indexes of the configuration port
	localparam logic [1:0] REG_HALF_MAX = 2'd0;
	localparam logic [1:0] REG_MAT_RATE = 2'd1;
	localparam logic [1:0] REG_DEM_RATE = 2'd2;
	localparam logic [1:0] REG_TIME_STEP = 2'd3;

	// sideband that rides along the exponent path
	typedef struct packed {
		logic [16:0] e;
		logic [16:0] m;
		logic        rz;
	} vmu_side_t;

endpackage
`default_nettype wire

@@ rtl/core/vmu_frac_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_frac_div
// Pipelined restoring divider: quo = floor(num * 2^FRAC / den) for num <= den,
// one quotient bit per stage, FRAC+1 stages, sideband travels with the data.
// ----------------------------------------------------------------------------
module vmu_frac_div #(
	parameter int WN     = 33,
	parameter int FRAC   = 16,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_i,
	input  wire logic [WN-1:0]     num_i,
	input  wire logic [WN-1:0]     den_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   vld_o,
	output logic [FRAC:0]          quo_o,
	output logic [SIDE_W-1:0]      side_o
);

	localparam int NS = FRAC + 1;

	logic [WN-1:0]     rem_s  [NS];
	logic [WN-1:0]     den_s  [NS];
	logic [FRAC:0]     quo_s  [NS];
	logic [SIDE_W-1:0] side_s [NS];
	logic [NS-1:0]     vld_s;

	// integer bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		den_s[0]  <= den_i;
		side_s[0] <= side_i;
		if (num_i >= den_i) begin
			quo_s[0] <= (FRAC+1)'(1);
			rem_s[0] <= num_i - den_i;
		end else begin
			quo_s[0] <= '0;
			rem_s[0] <= num_i;
		end
	end

	// one fraction bit per stage
	for (genvar i = 1; i < NS; i++) begin : g_stage
		logic [WN:0] sh;
		logic [WN:0] dx;
		logic        ge;

		assign sh = {rem_s[i-1], 1'b0};
		assign dx = {1'b0, den_s[i-1]};
		assign ge = (sh >= dx);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			den_s[i]  <= den_s[i-1];
			side_s[i] <= side_s[i-1];
			quo_s[i]  <= {quo_s[i-1][FRAC-1:0], ge};
			rem_s[i]  <= ge ? WN'(sh - dx) : WN'(sh);
		end
	end

	assign vld_o  = vld_s[NS-1];
	assign quo_o  = quo_s[NS-1];
	assign side_o = side_s[NS-1];

endmodule
`default_nettype wire

@@ rtl/core/vmu_series_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_series_step
// One term of the exp(-z) series: t_k = floor(floor(t*z/2^32)/k), added or
// subtracted into the running sum. Three stages: multiply, reciprocal, fix-up.
// ----------------------------------------------------------------------------
module vmu_series_step #(
	parameter int STEP_K = 2,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_i,
	input  wire logic [31:0]       term_i,
	input  wire logic [31:0]       z_i,
	input  wire logic [33:0]       sum_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   vld_o,
	output logic [31:0]            term_o,
	output logic [31:0]            z_o,
	output logic [33:0]            sum_o,
	output logic [SIDE_W-1:0]      side_o
);

	import vmu_pkg::*;

	localparam logic [35:0] RECIP = 36'((64'd1 << RECIP_SHIFT) / STEP_K);
	localparam logic [35:0] KVAL  = 36'(STEP_K);
	localparam bit          ODD   = (STEP_K % 2) == 1;

	logic [2:0]        vld_s;
	logic [31:0]       hi_s1, hi_s2, q0_s2;
	logic [31:0]       z_s1, z_s2;
	logic [33:0]       sum_s1, sum_s2;
	logic [SIDE_W-1:0] side_s1, side_s2;
	logic [63:0]       prod;
	logic [67:0]       rprod;
	logic [35:0]       rem;
	logic [31:0]       q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[1:0], vld_i};
		end
	end

	// stage 1: t*z
	assign prod = 64'(term_i) * 64'(z_i);

	always_ff @(posedge clk) begin
		hi_s1   <= prod[63:32];
		z_s1    <= z_i;
		sum_s1  <= sum_i;
		side_s1 <= side_i;
	end

	// stage 2: quotient estimate by reciprocal, low by at most one
	assign rprod = 68'(hi_s1) * 68'(RECIP);

	always_ff @(posedge clk) begin
		q0_s2   <= rprod[RECIP_SHIFT+31:RECIP_SHIFT];
		hi_s2   <= hi_s1;
		z_s2    <= z_s1;
		sum_s2  <= sum_s1;
		side_s2 <= side_s1;
	end

	// stage 3: correct and accumulate
	always_comb begin
		rem = 36'(hi_s2) - 36'(q0_s2) * KVAL;
		q   = (rem >= KVAL) ? q0_s2 + 32'd1 : q0_s2;
	end

	always_ff @(posedge clk) begin
		term_o <= q;
		z_o    <= z_s2;
		side_o <= side_s2;
		sum_o  <= ODD ? sum_s2 - 34'(q) : sum_s2 + 34'(q);
	end

	assign vld_o = vld_s[2];

endmodule
`default_nettype wire

@@ rtl/core/vmu_exp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_exp
// exp(-x) in Q1.32 for x in Q.16: split x*log2(e) into integer n and
// fraction, series for the fraction, then shift right by n.
// ----------------------------------------------------------------------------
module vmu_exp #(
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_i,
	input  wire logic [20:0]       x_i,
	input  wire logic              big_i,
	input  wire logic [SIDE_W-1:0] side_i,
	output logic                   vld_o,
	output logic [32:0]            exp_o,
	output logic [SIDE_W-1:0]      side_o
);

	import vmu_pkg::*;

	localparam int NSTEP = SERIES_TERMS - 1;
	localparam int CW    = SIDE_W + 6;

	logic [3:0]        vld_s;
	logic [21:0]       y_s1;
	logic              zero_s1, zero_s2, zero_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic [4:0]        n_s2, n_s3;
	logic [31:0]       z_s2, z_s3, term_s3;
	logic [33:0]       sum_s3;
	logic [51:0]       yprod;
	logic [47:0]       zprod;

	// chain of series steps
	logic [NSTEP:0]    c_vld;
	logic [31:0]       c_term [NSTEP+1];
	logic [31:0]       c_z    [NSTEP+1];
	logic [33:0]       c_sum  [NSTEP+1];
	logic [CW-1:0]     c_side [NSTEP+1];

	logic [4:0]        n_f;
	logic              zero_f;
	logic [SIDE_W-1:0] side_f;
	logic [32:0]       sum_cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {c_vld[NSTEP], vld_s[1:0], vld_i};
		end
	end

	// stage 1: y = x*log2(e)
	assign yprod = 52'(x_i) * 52'(LOG2E_Q30);

	always_ff @(posedge clk) begin
		y_s1    <= yprod[51:30];
		zero_s1 <= big_i;
		side_s1 <= side_i;
	end

	// stage 2: integer part and fraction*ln2
	assign zprod = 48'(y_s1[15:0]) * 48'(LN2_Q32);

	always_ff @(posedge clk) begin
		n_s2    <= y_s1[20:16];
		zero_s2 <= zero_s1 | y_s1[21];
		z_s2    <= zprod[47:16];
		side_s2 <= side_s1;
	end

	// stage 3: first term is z itself
	always_ff @(posedge clk) begin
		term_s3 <= z_s2;
		z_s3    <= z_s2;
		sum_s3  <= 34'h1_0000_0000 - 34'(z_s2);
		n_s3    <= n_s2;
		zero_s3 <= zero_s2;
		side_s3 <= side_s2;
	end

	assign c_vld[0]  = vld_s[2];
	assign c_term[0] = term_s3;
	assign c_z[0]    = z_s3;
	assign c_sum[0]  = sum_s3;
	assign c_side[0] = {n_s3, zero_s3, side_s3};

	for (genvar i = 0; i < NSTEP; i++) begin : g_term
		vmu_series_step #(
			.STEP_K (i + 2),
			.SIDE_W (CW)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (c_vld[i]),
			.term_i (c_term[i]),
			.z_i    (c_z[i]),
			.sum_i  (c_sum[i]),
			.side_i (c_side[i]),
			.vld_o  (c_vld[i+1]),
			.term_o (c_term[i+1]),
			.z_o    (c_z[i+1]),
			.sum_o  (c_sum[i+1]),
			.side_o (c_side[i+1])
		);
	end

	// final: cap at 1.0, shift by n
	assign {n_f, zero_f, side_f} = c_side[NSTEP];
	assign sum_cap = (c_sum[NSTEP] > 34'h1_0000_0000) ? 33'h1_0000_0000 :
		c_sum[NSTEP][32:0];

	always_ff @(posedge clk) begin
		exp_o  <= zero_f ? 33'd0 : (sum_cap >> n_f);
		side_o <= side_f;
	end

	assign vld_o = vld_s[3];

endmodule
`default_nettype wire

@@ rtl/core/vessel_maturity_update_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vessel_maturity_update_core
// Relaxes a segment's maturity toward the growth-factor dependent equilibrium.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is never raised, every stage advances
// each cycle and the receiver cannot stall.
// Depth is set by the two pipelined dividers (17 stages each), the four-stage
// reciprocal divide by 1e9 and the eleven three-stage exp series terms.
// Reset clears stage valid bits and loads the register defaults.
module vessel_maturity_update_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item command
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] concentration,
	input  wire logic [16:0] maturity_in,
	// result
	output logic             done,
	output logic [16:0]      maturity_out,
	output logic             rates_zero,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	import vmu_pkg::*;

	localparam int SW = $bits(vmu_side_t);

	// configuration registers
	logic [31:0] k_q;
	logic [23:0] rm_q, rd_q, dt_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= 32'd6500;
			rm_q <= 24'd500;
			rd_q <= 24'd80000;
			dt_q <= 24'd1000;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_HALF_MAX:  k_q  <= pwdata;
				REG_MAT_RATE:  rm_q <= pwdata[23:0];
				REG_DEM_RATE:  rd_q <= pwdata[23:0];
				REG_TIME_STEP: dt_q <= pwdata[23:0];
				default:       k_q  <= k_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HALF_MAX:  prdata = k_q;
			REG_MAT_RATE:  prdata = {8'd0, rm_q};
			REG_DEM_RATE:  prdata = {8'd0, rd_q};
			REG_TIME_STEP: prdata = {8'd0, dt_q};
			default:       prdata = '0;
		endcase
	end

	// stage 1: clamp maturity, K + c
	logic        vld_s1, dz_s1;
	logic [31:0] c_s1;
	logic [16:0] m_s1;
	logic [32:0] den_s1, den;

	assign den = {1'b0, k_q} + {1'b0, concentration};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		c_s1   <= concentration;
		m_s1   <= (maturity_in > MAT_ONE) ? MAT_ONE : maturity_in;
		den_s1 <= den;
		dz_s1  <= (den == 33'd0);
	end

	// f = c/(K+c), g = K/(K+c), Q1.16
	logic        f_vld, g_vld;
	logic [16:0] f_quo, g_quo, f_m;
	logic        g_dz;

	vmu_frac_div #(.WN(33), .FRAC(MFB), .SIDE_W(MAT_W)) u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (vld_s1),
		.num_i  ({1'b0, c_s1}),
		.den_i  (den_s1),
		.side_i (m_s1),
		.vld_o  (f_vld),
		.quo_o  (f_quo),
		.side_o (f_m)
	);

	vmu_frac_div #(.WN(33), .FRAC(MFB), .SIDE_W(1)) u_gdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (vld_s1),
		.num_i  ({1'b0, k_q}),
		.den_i  (den_s1),
		.side_i (dz_s1),
		.vld_o  (g_vld),
		.quo_o  (g_quo),
		.side_o (g_dz)
	);

	// stage 2: peak rates times occupancy
	logic        vld_s2, dz_s2;
	logic [40:0] af_s2, bg_s2;
	logic [16:0] m_s2;

	always_ff @(posedge clk) begin
		af_s2 <= 41'(rd_q) * 41'(f_quo);
		bg_s2 <= 41'(rm_q) * 41'(g_quo);
		m_s2  <= f_m;
		dz_s2 <= g_dz;
	end

	// stage 3: scale by m and 1-m
	logic        vld_s3, dz_s3;
	logic [41:0] a_s3, b_s3;
	logic [16:0] m_s3;
	logic [57:0] a_prod, b_prod;

	assign a_prod = 58'(af_s2) * 58'(m_s2);
	assign b_prod = 58'(bg_s2) * 58'(17'(MAT_ONE - m_s2));

	always_ff @(posedge clk) begin
		a_s3  <= a_prod[MFB+41:MFB];
		b_s3  <= b_prod[MFB+41:MFB];
		m_s3  <= m_s2;
		dz_s3 <= dz_s2;
	end

	// stage 4: total rate
	logic        vld_s4, rz_s4;
	logic [41:0] s_s4, b_s4, s_sum;
	logic [16:0] m_s4;

	assign s_sum = a_s3 + b_s3;

	always_ff @(posedge clk) begin
		s_s4  <= s_sum;
		b_s4  <= b_s3;
		m_s4  <= m_s3;
		rz_s4 <= dz_s3 | (s_sum == 42'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= f_vld & g_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// equilibrium e = b/s
	logic        e_vld;
	logic [16:0] e_quo;
	logic [59:0] e_side;
	logic [41:0] e_s;
	logic [16:0] e_m;
	logic        e_rz;

	vmu_frac_div #(.WN(42), .FRAC(MFB), .SIDE_W(60)) u_ediv (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (vld_s4),
		.num_i  (b_s4),
		.den_i  (s_s4),
		.side_i ({s_s4, m_s4, rz_s4}),
		.vld_o  (e_vld),
		.quo_o  (e_quo),
		.side_o (e_side)
	);

	assign {e_s, e_m, e_rz} = e_side;

	// stages 5-7: dt*s in two partial products, then saturation test
	logic        vld_s5, vld_s6, vld_s7, big_s7;
	logic [44:0] pl_s5, ph_s5;
	logic [65:0] p_s6;
	logic [41:0] pn_s7;
	vmu_side_t   sd_s5, sd_s6, sd_s7;

	always_ff @(posedge clk) begin
		pl_s5   <= 45'(dt_q) * 45'(e_s[20:0]);
		ph_s5   <= 45'(dt_q) * 45'(e_s[41:21]);
		sd_s5   <= '{e: e_quo, m: e_m, rz: e_rz};
		p_s6    <= 66'(pl_s5) + (66'(ph_s5) << 21);
		sd_s6   <= sd_s5;
		big_s7  <= (p_s6 >= 66'(XDEN));
		// below the limit dt*s fits 51 bits; drop the 2^9 factor of 1e9
		pn_s7   <= (p_s6 >= 66'(XDEN)) ? 42'd0 : p_s6[50:9];
		sd_s7   <= sd_s6;
	end

	// stages 8-11: x = floor(dt*s / 1e9) by reciprocal, estimate low by at most one
	logic        vld_s8, vld_s9, vld_s10, vld_s11;
	logic        big_s8, big_s9, big_s10, big_s11;
	logic [42:0] rl_s8, rh_s8;
	logic [41:0] pn_s8, pn_s9, pn_s10;
	logic [20:0] q_s9, q_s10, x_s11;
	logic [41:0] qd_s10;
	vmu_side_t   sd_s8, sd_s9, sd_s10, sd_s11;
	logic [63:0] rsum;
	logic [41:0] xrem;

	assign rsum = 64'(rl_s8) + (64'(rh_s8) << 21);
	assign xrem = pn_s10 - qd_s10;

	always_ff @(posedge clk) begin
		rl_s8   <= 43'(pn_s7[20:0]) * 43'(X_RECIP);
		rh_s8   <= 43'(pn_s7[41:21]) * 43'(X_RECIP);
		pn_s8   <= pn_s7;
		big_s8  <= big_s7;
		sd_s8   <= sd_s7;
		q_s9    <= rsum[62:42];
		pn_s9   <= pn_s8;
		big_s9  <= big_s8;
		sd_s9   <= sd_s8;
		qd_s10  <= 42'(q_s9) * 42'(X_DIV);
		q_s10   <= q_s9;
		pn_s10  <= pn_s9;
		big_s10 <= big_s9;
		sd_s10  <= sd_s9;
		x_s11   <= (xrem >= 42'(X_DIV)) ? q_s10 + 21'd1 : q_s10;
		big_s11 <= big_s10;
		sd_s11  <= sd_s10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s5  <= e_vld;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// E = exp(-x)
	logic        ex_vld;
	logic [32:0] ex_val;
	logic [SW-1:0] ex_side;
	vmu_side_t   ex_sd;

	vmu_exp #(.SIDE_W(SW)) u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (vld_s11),
		.x_i    (x_s11),
		.big_i  (big_s11),
		.side_i (sd_s11),
		.vld_o  (ex_vld),
		.exp_o  (ex_val),
		.side_o (ex_side)
	);

	assign ex_sd = vmu_side_t'(ex_side);

	// stage 12: |m-e| * E
	logic        vld_s12, ge_s12;
	logic [49:0] prod_s12;
	vmu_side_t   sd_s12;
	logic        ge;
	logic [16:0] dif;

	assign ge  = (ex_sd.m >= ex_sd.e);
	assign dif = ge ? 17'(ex_sd.m - ex_sd.e) : 17'(ex_sd.e - ex_sd.m);

	always_ff @(posedge clk) begin
		prod_s12 <= 50'(dif) * 50'(ex_val);
		ge_s12   <= ge;
		sd_s12   <= ex_sd;
	end

	// stage 13: relax toward e or hold m when rates are zero, cap at 1.0, output register
	logic        done_q, rz_q;
	logic [16:0] mo_q;
	logic [16:0] adj;
	logic [17:0] rel;

	assign adj = prod_s12[48:32];
	assign rel = ge_s12 ? 18'(sd_s12.e) + 18'(adj) : 18'(sd_s12.e) - 18'(adj);

	always_ff @(posedge clk) begin
		if (sd_s12.rz) begin
			mo_q <= sd_s12.m;
		end else begin
			mo_q <= (rel > 18'(MAT_ONE)) ? MAT_ONE : rel[16:0];
		end
		rz_q <= sd_s12.rz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s12 <= ex_vld;
			done_q  <= vld_s12;
		end
	end

	assign done         = done_q;
	assign maturity_out = mo_q;
	assign rates_zero   = rz_q;

`ifndef ASSERT_OFF
	localparam int LATENCY = 84;

	// every accepted command yields exactly one result at fixed latency
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result missing after accepted command");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted command");

	// saturation at 1.0 holds on every result
	a_mat_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> maturity_out <= MAT_ONE)
		else $error("maturity above one");
`endif

endmodule
`default_nettype wire
